/* design/source_tokenizer_top_macros.svh */
// ----------------------------------------------------------------------------
// Source tokenizer assertion macros
// Shared concurrent assertion forms, checked on the rising clock edge and
// disabled while the synchronous reset is held.
// ----------------------------------------------------------------------------
`ifndef SOURCE_TOKENIZER_TOP_MACROS_SVH
`define SOURCE_TOKENIZER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define STK_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("source tokenizer assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define STK_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("source tokenizer assertion failed");

`endif

/* design/stk_pkg.sv */
// ----------------------------------------------------------------------------
// Source tokenizer package
// Token codes, scanner modes, keyword table and the token bundle that travels
// from the scanner to the token output stage.
// ----------------------------------------------------------------------------
`default_nettype none

package stk_pkg;

    localparam int KW_CHARS        = 6;
    localparam int KW_IDX_W        = $clog2(KW_CHARS);
    localparam int KW_COUNT        = 19;
    localparam int MAX_TOKENS      = 3;
    localparam int TOK_CNT_W       = $clog2(MAX_TOKENS + 1);
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int OFFSET_BITS_DEF = 32;

    localparam logic [15:0] LEN_MAX = 16'hFFFF;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_LBRC  = 8'h7B;
    localparam logic [7:0] CH_RBRC  = 8'h7D;
    localparam logic [7:0] CH_UNDER = 8'h5F;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_WORD,
        MODE_NUMBER,
        MODE_SLASH,
        MODE_MINUS,
        MODE_COMMENT
    } t_mode;

    typedef enum logic [5:0] {
        TK_FN, TK_LET, TK_INT, TK_BOOL, TK_IF, TK_ELSE, TK_THEN, TK_WHILE,
        TK_SEND, TK_TRUE, TK_FALSE, TK_AND, TK_OR, TK_NOT, TK_IDENT, TK_LITERAL,
        TK_PLUS, TK_MINUS, TK_TIMES, TK_DIVIDE, TK_IS, TK_IS_LT, TK_IS_LTE,
        TK_IS_GT, TK_IS_GTE, TK_ASSIGN, TK_LPAREN, TK_RPAREN, TK_LBRACE,
        TK_RBRACE, TK_COLON, TK_SEMICOLON, TK_COMMA, TK_ARROW, TK_EOF, TK_INVALID
    } t_tok_type;

    typedef struct packed {
        t_tok_type   ttype;
        logic [31:0] start;
        logic [15:0] length;
    } t_token;

    typedef struct packed {
        logic   valid;
        t_token tok;
    } t_slot;

    // Tokens caused by one item, oldest in entry 0.
    typedef struct packed {
        t_token [MAX_TOKENS-1:0] tok;
        logic [TOK_CNT_W-1:0]    cnt;
    } t_bundle;

    // Keyword text is right-aligned: the last character sits in the low byte.
    localparam logic [8*KW_CHARS-1:0] KW_TEXT [KW_COUNT] = '{
        "fn", "let", "int", "bool", "if", "else", "then", "while", "send",
        "true", "false", "AND", "OR", "NOT", "is", "is_lt", "is_lte",
        "is_gt", "is_gte"
    };

    localparam logic [2:0] KW_LEN [KW_COUNT] = '{
        3'd2, 3'd3, 3'd3, 3'd4, 3'd2, 3'd4, 3'd4, 3'd5, 3'd4, 3'd4, 3'd5,
        3'd3, 3'd2, 3'd3, 3'd2, 3'd5, 3'd6, 3'd5, 3'd6
    };

    localparam t_tok_type KW_CODE [KW_COUNT] = '{
        TK_FN, TK_LET, TK_INT, TK_BOOL, TK_IF, TK_ELSE, TK_THEN, TK_WHILE,
        TK_SEND, TK_TRUE, TK_FALSE, TK_AND, TK_OR, TK_NOT, TK_IS, TK_IS_LT,
        TK_IS_LTE, TK_IS_GT, TK_IS_GTE
    };

    function automatic logic is_alpha(input logic [7:0] c);
        return c inside {[8'h61:8'h7A], [8'h41:8'h5A], CH_UNDER};
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c inside {CH_SPACE, CH_TAB, CH_LF, CH_CR};
    endfunction

    // chars holds the first word bytes, byte i at bits [8*i +: 8].
    function automatic t_tok_type word_type(input logic [8*KW_CHARS-1:0] chars,
                                            input logic [15:0] cnt);
        t_tok_type res;
        logic      hit;
        int        len;
        int        j;
        res = TK_IDENT;
        for (int k = 0; k < KW_COUNT; k++) begin
            len = int'(KW_LEN[k]);
            hit = (cnt == 16'(KW_LEN[k]));
            for (int i = 0; i < KW_CHARS; i++) begin
                j = (i < len) ? (len - 1 - i) : 0;
                if (i < len && chars[8*i +: 8] != KW_TEXT[k][8*j +: 8]) begin
                    hit = 1'b0;
                end
            end
            if (hit) begin
                res = KW_CODE[k];
            end
        end
        return res;
    endfunction

    function automatic t_tok_type symbol_type(input logic [7:0] c);
        t_tok_type res;
        case (c)
            CH_PLUS:  res = TK_PLUS;
            CH_MINUS: res = TK_MINUS;
            CH_STAR:  res = TK_TIMES;
            CH_SLASH: res = TK_DIVIDE;
            CH_EQ:    res = TK_ASSIGN;
            CH_LPAR:  res = TK_LPAREN;
            CH_RPAR:  res = TK_RPAREN;
            CH_LBRC:  res = TK_LBRACE;
            CH_RBRC:  res = TK_RBRACE;
            CH_COLON: res = TK_COLON;
            CH_SEMI:  res = TK_SEMICOLON;
            CH_COMMA: res = TK_COMMA;
            default:  res = TK_INVALID;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

/* design/stk_front.sv */
// ----------------------------------------------------------------------------
// Source tokenizer scanner
// Classifies each accepted byte against the pending token and builds the
// bundle of up to three tokens that the item causes.
// ----------------------------------------------------------------------------
`default_nettype none

module stk_front
    import stk_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [7:0] i_char_byte,
    input  wire logic       i_has_char,
    input  wire logic       i_end_of_input,
    output logic            o_wr,
    output t_bundle         o_bundle
);

    t_mode                   r_mode,   n_mode;
    logic [OFFSET_BITS-1:0]  r_begin,  n_begin;
    logic [15:0]             r_count,  n_count;
    logic                    r_point,  n_point;
    logic [OFFSET_BITS-1:0]  r_offset, n_offset;
    logic [8*KW_CHARS-1:0]   r_word,   n_word;

    t_slot                   slots [4];
    logic                    done;
    logic [7:0]              c;

    function automatic t_slot flush_slot(input t_mode m, input logic [31:0] start,
                                         input logic [15:0] cnt, input t_tok_type wt);
        t_slot s;
        s = '0;
        s.tok.start = start;
        case (m)
            MODE_WORD: begin
                s.valid = 1'b1;
                s.tok.ttype = wt;
                s.tok.length = cnt;
            end
            MODE_NUMBER: begin
                s.valid = 1'b1;
                s.tok.ttype = TK_LITERAL;
                s.tok.length = cnt;
            end
            MODE_SLASH: begin
                s.valid = 1'b1;
                s.tok.ttype = TK_DIVIDE;
                s.tok.length = 16'd1;
            end
            MODE_MINUS: begin
                s.valid = 1'b1;
                s.tok.ttype = TK_MINUS;
                s.tok.length = 16'd1;
            end
            default: s.valid = 1'b0;
        endcase
        return s;
    endfunction

    function automatic t_slot make_slot(input t_tok_type t, input logic [31:0] start,
                                        input logic [15:0] len);
        t_slot s;
        s.valid = 1'b1;
        s.tok.ttype = t;
        s.tok.start = start;
        s.tok.length = len;
        return s;
    endfunction

    assign c = i_char_byte;

    always_comb begin
        n_mode   = r_mode;
        n_begin  = r_begin;
        n_count  = r_count;
        n_point  = r_point;
        n_offset = r_offset;
        n_word   = r_word;
        done     = 1'b0;
        for (int i = 0; i < 4; i++) begin
            slots[i] = '0;
        end

        if (i_has_char) begin
            case (r_mode)
                MODE_COMMENT: begin
                    if (c == CH_LF) begin
                        n_mode = MODE_IDLE;
                    end
                    done = 1'b1;
                end
                MODE_WORD: begin
                    if (is_alpha(c) || is_digit(c)) begin
                        if (r_count < 16'(KW_CHARS)) begin
                            n_word[8*r_count[KW_IDX_W-1:0] +: 8] = c;
                        end
                        n_count = (r_count == LEN_MAX) ? r_count : r_count + 16'd1;
                        done = 1'b1;
                    end else begin
                        slots[0] = flush_slot(r_mode, 32'(r_begin), r_count,
                                              word_type(r_word, r_count));
                        n_mode = MODE_IDLE;
                    end
                end
                MODE_NUMBER: begin
                    if (is_digit(c) || (c == CH_POINT && !r_point)) begin
                        if (c == CH_POINT) begin
                            n_point = 1'b1;
                        end
                        n_count = (r_count == LEN_MAX) ? r_count : r_count + 16'd1;
                        done = 1'b1;
                    end else begin
                        slots[0] = flush_slot(r_mode, 32'(r_begin), r_count, TK_LITERAL);
                        n_mode = MODE_IDLE;
                    end
                end
                MODE_SLASH: begin
                    if (c == CH_SLASH) begin
                        n_mode = MODE_COMMENT;
                        done = 1'b1;
                    end else begin
                        slots[0] = flush_slot(r_mode, 32'(r_begin), r_count, TK_DIVIDE);
                        n_mode = MODE_IDLE;
                    end
                end
                MODE_MINUS: begin
                    if (c == CH_GT) begin
                        slots[0] = make_slot(TK_ARROW, 32'(r_begin), 16'd2);
                        n_mode = MODE_IDLE;
                        done = 1'b1;
                    end else begin
                        slots[0] = flush_slot(r_mode, 32'(r_begin), r_count, TK_MINUS);
                        n_mode = MODE_IDLE;
                    end
                end
                default: n_mode = MODE_IDLE;
            endcase

            if (!done) begin
                if (is_space(c)) begin
                    n_mode = MODE_IDLE;
                end else if (is_alpha(c)) begin
                    n_mode  = MODE_WORD;
                    n_begin = r_offset;
                    n_count = 16'd1;
                    n_point = 1'b0;
                    n_word[7:0] = c;
                end else if (is_digit(c)) begin
                    n_mode  = MODE_NUMBER;
                    n_begin = r_offset;
                    n_count = 16'd1;
                    n_point = 1'b0;
                end else if (c == CH_SLASH) begin
                    n_mode  = MODE_SLASH;
                    n_begin = r_offset;
                    n_count = 16'd1;
                    n_point = 1'b0;
                end else if (c == CH_MINUS) begin
                    n_mode  = MODE_MINUS;
                    n_begin = r_offset;
                    n_count = 16'd1;
                    n_point = 1'b0;
                end else begin
                    slots[1] = make_slot(symbol_type(c), 32'(r_offset), 16'd1);
                end
            end
            n_offset = r_offset + 1'b1;
        end

        // Flush what this byte left pending, report end of text, start over.
        if (i_end_of_input) begin
            slots[2] = flush_slot(n_mode, 32'(n_begin), n_count,
                                  word_type(n_word, n_count));
            slots[3] = make_slot(TK_EOF, 32'(n_offset), 16'd0);
            n_mode   = MODE_IDLE;
            n_begin  = '0;
            n_count  = '0;
            n_point  = 1'b0;
            n_offset = '0;
        end
    end

    // Pack the valid tokens in order.
    always_comb begin
        o_bundle = '0;
        for (int i = 0; i < 4; i++) begin
            if (slots[i].valid && o_bundle.cnt < TOK_CNT_W'(MAX_TOKENS)) begin
                o_bundle.tok[o_bundle.cnt] = slots[i].tok;
                o_bundle.cnt = o_bundle.cnt + 1'b1;
            end
        end
    end

    assign o_wr = i_accept && (o_bundle.cnt != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_IDLE;
            r_begin  <= '0;
            r_count  <= '0;
            r_point  <= 1'b0;
            r_offset <= '0;
        end else if (i_accept) begin
            r_mode   <= n_mode;
            r_begin  <= n_begin;
            r_count  <= n_count;
            r_point  <= n_point;
            r_offset <= n_offset;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_word <= n_word;
        end
    end

endmodule

`default_nettype wire

/* design/stk_queue.sv */
// ----------------------------------------------------------------------------
// Source tokenizer bundle queue
// Short first-in first-out buffer of token bundles between the scanner and
// the token output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module stk_queue
    import stk_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_wr,
    input  t_bundle       i_wr_data,
    output logic          o_full,
    input  wire logic     i_rd,
    output t_bundle       o_rd_data,
    output logic          o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_bundle            r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               wr_en;
    logic               rd_en;

    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign wr_en     = i_wr && !o_full;
    assign rd_en     = i_rd && !o_empty;
    assign o_rd_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

/* design/stk_back.sv */
// ----------------------------------------------------------------------------
// Source tokenizer token output stage
// Walks the head bundle one token per cycle, while the consumer pops, into a
// registered output that is presented as a queue to the consumer.
// ----------------------------------------------------------------------------
`default_nettype none

`include "source_tokenizer_top_macros.svh"

module stk_back
    import stk_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  t_bundle       i_q_data,
    input  wire logic     i_q_empty,
    output logic          o_q_pop,
    input  wire logic     i_pop,
    output logic          o_empty,
    output t_token        o_token,
    output logic          o_last
);

    logic                 r_valid;
    logic [TOK_CNT_W-1:0] r_slot;
    t_token               r_tok;
    logic                 r_last;
    logic                 load;
    logic                 take;
    logic                 last;

    assign load    = !r_valid || i_pop;
    assign take    = load && !i_q_empty;
    assign last    = (r_slot == i_q_data.cnt - 1'b1);
    assign o_q_pop = take && last;
    assign o_empty = !r_valid;
    assign o_token = r_tok;
    assign o_last  = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_slot  <= '0;
        end else begin
            if (load) begin
                r_valid <= !i_q_empty;
            end
            if (take) begin
                r_slot <= last ? '0 : r_slot + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_tok  <= i_q_data.tok[r_slot];
            r_last <= last;
        end
    end

    `STK_ASSERT_IMPL(a_bundle_not_empty, i_clk, i_rst_n, !i_q_empty, i_q_data.cnt != '0)
    `STK_ASSERT_IMPL(a_slot_in_bundle, i_clk, i_rst_n, !i_q_empty, r_slot < i_q_data.cnt)
    `STK_ASSERT_IMPL(a_slot_idle_zero, i_clk, i_rst_n, i_q_empty, r_slot == '0)
    `STK_ASSERT_NEXT(a_slot_restart, i_clk, i_rst_n, o_q_pop, r_slot == '0 && r_valid)

endmodule

`default_nettype wire

/* design/source_tokenizer_top.sv */
// Source tokenizer: push one source byte per item (or an empty item that only
// carries the end marker); each item yields zero to three tokens, read out as
// type code, start offset, saturated length and a flag on the last token of
// the item. A new item is taken every cycle while full is low; tokens leave
// one per cycle while the consumer pops, and the bundle queue between the
// scanner and the output stage absorbs the difference when an item causes
// more than one token. When the output stage is free, the first token of an
// item is written into the bundle queue on the edge that accepts the item,
// then loaded into the registered output, from where it can be popped.
// After an end marker the offset counts from zero again.
// ----------------------------------------------------------------------------
// Source tokenizer top level
// Scanner, bundle queue and token output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module source_tokenizer_top
    import stk_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  i_char_byte,
    input  wire logic        i_has_char,
    input  wire logic        i_end_of_input,
    output logic             empty,
    input  wire logic        pop,
    output logic [5:0]       o_token_type,
    output logic [31:0]      o_token_start,
    output logic [15:0]      o_token_length,
    output logic             o_last_result
);

    logic    accept;
    logic    q_wr;
    t_bundle q_wr_data;
    logic    q_full;
    logic    q_empty;
    logic    q_pop;
    t_bundle q_rd_data;
    t_token  out_tok;

    assign full   = q_full;
    assign accept = push && !q_full;

    stk_front #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_char_byte    (i_char_byte),
        .i_has_char     (i_has_char),
        .i_end_of_input (i_end_of_input),
        .o_wr           (q_wr),
        .o_bundle       (q_wr_data)
    );

    stk_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (q_wr),
        .i_wr_data (q_wr_data),
        .o_full    (q_full),
        .i_rd      (q_pop),
        .o_rd_data (q_rd_data),
        .o_empty   (q_empty)
    );

    stk_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_data  (q_rd_data),
        .i_q_empty (q_empty),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_token   (out_tok),
        .o_last    (o_last_result)
    );

    assign o_token_type   = out_tok.ttype;
    assign o_token_start  = out_tok.start;
    assign o_token_length = out_tok.length;

endmodule

`default_nettype wire
